/* hw/rtl/lss_pkg.sv */
// Shared constants and types of the 3x3 linear system solver.
package lss_pkg;

  localparam int LSS_VALUE_WIDTH   = 24;
  localparam int LSS_FRACTION_BITS = 16;

  typedef struct packed {
    logic clip;
    logic zero;
  } lss_flags_t;

endpackage

/* hw/rtl/lss_dot3.sv */
// Three-term dot product of W-bit values with (2W+1)-bit cofactors, split multipliers.
module lss_dot3 import lss_pkg::*; #(
  parameter int W  = LSS_VALUE_WIDTH,
  parameter int PW = 3 * LSS_VALUE_WIDTH + 3
) (
  input  logic                   clk,
  input  logic                   adv,
  input  logic signed [W-1:0]    x [3],
  input  logic signed [2*W:0]    c [3],
  output logic signed [PW-1:0]   sum
);

  logic signed [2*W:0]  lo_r [3];
  logic signed [2*W:0]  hi_r [3];
  logic signed [PW-1:0] p_r  [3];
  logic signed [PW-1:0] sum_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        lo_r[j] <= (2*W+1)'(x[j] * $signed({1'b0, c[j][W-1:0]}));
        hi_r[j] <= (2*W+1)'(x[j] * $signed(c[j][2*W:W]));
        p_r[j]  <= (PW'(hi_r[j]) <<< W) + PW'(lo_r[j]);
      end
      sum_r <= p_r[0] + p_r[1] + p_r[2];
    end
  end

  assign sum = sum_r;

endmodule

/* hw/rtl/lss_lane.sv */
// One solution lane: magnitude, rounding offset, range check, pipelined divide, saturation.
module lss_lane import lss_pkg::*; #(
  parameter int W = LSS_VALUE_WIDTH,
  parameter int F = LSS_FRACTION_BITS
) (
  input  logic                       clk,
  input  logic                       adv,
  input  logic signed [3*W+2:0]      num_in,
  input  logic signed [3*W+2:0]      det_in,
  output logic signed [W-1:0]        sol,
  output lss_flags_t                 flags
);

  localparam int PW = 3 * W + 3;
  localparam int RW = PW + W + F + 1;

  logic [PW-1:0] nm_r, dm_r, den2_r;
  logic          neg1_r, zero1_r, neg2_r, zero2_r;
  logic [RW-1:0] num_r;

  logic [RW-1:0] rem_r  [W+1];
  logic [PW-1:0] den_r  [W+1];
  logic [W-1:0]  q_r    [W+1];
  logic          neg_r  [W+1];
  logic          zero_r [W+1];
  logic          ovf_r  [W+1];

  logic signed [W-1:0] sol_r;
  lss_flags_t          flags_r;

  logic [W-1:0] lim;
  logic         clip;
  logic [W-1:0] magf;

  always_ff @(posedge clk) begin
    if (adv) begin
      nm_r    <= num_in[PW-1] ? PW'(-num_in) : PW'(num_in);
      dm_r    <= det_in[PW-1] ? PW'(-det_in) : PW'(det_in);
      neg1_r  <= num_in[PW-1] ^ det_in[PW-1];
      zero1_r <= (det_in == '0);
      num_r   <= (RW'(nm_r) << F) + RW'(dm_r >> 1);
      den2_r  <= dm_r;
      neg2_r  <= neg1_r;
      zero2_r <= zero1_r;
      rem_r[0]  <= num_r;
      den_r[0]  <= den2_r;
      q_r[0]    <= '0;
      neg_r[0]  <= neg2_r;
      zero_r[0] <= zero2_r;
      ovf_r[0]  <= (num_r >> W) >= RW'(den2_r);
    end
  end

  for (genvar s = 0; s < W; s++) begin : g_div
    logic [RW:0] trial;
    assign trial = {1'b0, rem_r[s]} - {1'b0, RW'(den_r[s]) << (W - 1 - s)};
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[s+1]  <= trial[RW] ? rem_r[s] : trial[RW-1:0];
        q_r[s+1]    <= {q_r[s][W-2:0], ~trial[RW]};
        den_r[s+1]  <= den_r[s];
        neg_r[s+1]  <= neg_r[s];
        zero_r[s+1] <= zero_r[s];
        ovf_r[s+1]  <= ovf_r[s];
      end
    end
  end

  always_comb begin
    lim  = neg_r[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    clip = ovf_r[W] || (q_r[W] > lim);
    magf = clip ? lim : q_r[W];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (zero_r[W]) begin
        sol_r        <= '0;
        flags_r.clip <= 1'b0;
      end else begin
        sol_r        <= neg_r[W] ? $signed(-magf) : $signed(magf);
        flags_r.clip <= clip;
      end
      flags_r.zero <= zero_r[W];
    end
  end

  assign sol   = sol_r;
  assign flags = flags_r;

endmodule

/* hw/rtl/linear_system_3x3_solver.sv */
// Top level of the 3x3 linear system solver: cofactors, four dot-product lanes, three divide lanes.
//
//   channel | ports                                  | direction
//   in      | in_valid, in_stall, in_a_r*_c*, in_rhs_* | request in
//   out     | out_valid, out_stall, out_sol_*, flags  | result out
//
// One request per cycle is accepted while in_stall is low; out_valid marks its result at the output.
// The divider resolves one quotient bit per stage in each of three lanes.
// Reset (rst_n low, synchronous) clears only the valid bits; data registers keep their contents.
// A stalled result freezes the whole pipeline; in_stall follows that condition.
module linear_system_3x3_solver import lss_pkg::*; #(
  parameter int VALUE_WIDTH   = LSS_VALUE_WIDTH,
  parameter int FRACTION_BITS = LSS_FRACTION_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [VALUE_WIDTH-1:0] in_a_r0_c0,
  input  logic signed [VALUE_WIDTH-1:0] in_a_r0_c1,
  input  logic signed [VALUE_WIDTH-1:0] in_a_r0_c2,
  input  logic signed [VALUE_WIDTH-1:0] in_a_r1_c0,
  input  logic signed [VALUE_WIDTH-1:0] in_a_r1_c1,
  input  logic signed [VALUE_WIDTH-1:0] in_a_r1_c2,
  input  logic signed [VALUE_WIDTH-1:0] in_a_r2_c0,
  input  logic signed [VALUE_WIDTH-1:0] in_a_r2_c1,
  input  logic signed [VALUE_WIDTH-1:0] in_a_r2_c2,
  input  logic signed [VALUE_WIDTH-1:0] in_rhs_0,
  input  logic signed [VALUE_WIDTH-1:0] in_rhs_1,
  input  logic signed [VALUE_WIDTH-1:0] in_rhs_2,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [VALUE_WIDTH-1:0] out_sol_0,
  output logic signed [VALUE_WIDTH-1:0] out_sol_1,
  output logic signed [VALUE_WIDTH-1:0] out_sol_2,
  output logic                          out_singular,
  output logic                          out_clipped
);

  localparam int W   = VALUE_WIDTH;
  localparam int PW  = 3 * W + 3;
  localparam int LAT = W + 10;

  function automatic logic signed [2*W-1:0] smul(logic signed [W-1:0] p,
                                                 logic signed [W-1:0] q);
    return (2*W)'(p) * (2*W)'(q);
  endfunction

  logic adv;
  logic [LAT-1:0] v_r;
  logic out_valid_r;

  logic signed [W-1:0]   a_r [3][3];
  logic signed [W-1:0]   b_r [3];
  logic signed [W-1:0]   r0_s2_r [3], r0_s3_r [3];
  logic signed [W-1:0]   b_s2_r [3], b_s3_r [3];
  logic signed [2*W-1:0] pm_r [3][3];
  logic signed [2*W-1:0] pn_r [3][3];
  logic signed [2*W:0]   adj_r [3][3];

  logic signed [2*W:0]   det_c [3];
  logic signed [PW-1:0]  det_sum;
  logic signed [PW-1:0]  n_sum [3];
  logic signed [W-1:0]   sol   [3];
  lss_flags_t            flg   [3];

  logic signed [W-1:0] sol_r [3];
  logic                singular_r, clipped_r;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v_r         <= {v_r[LAT-2:0], in_valid};
      out_valid_r <= v_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r[0][0] <= in_a_r0_c0; a_r[0][1] <= in_a_r0_c1; a_r[0][2] <= in_a_r0_c2;
      a_r[1][0] <= in_a_r1_c0; a_r[1][1] <= in_a_r1_c1; a_r[1][2] <= in_a_r1_c2;
      a_r[2][0] <= in_a_r2_c0; a_r[2][1] <= in_a_r2_c1; a_r[2][2] <= in_a_r2_c2;
      b_r[0] <= in_rhs_0; b_r[1] <= in_rhs_1; b_r[2] <= in_rhs_2;

      pm_r[0][0] <= smul(a_r[1][1], a_r[2][2]); pn_r[0][0] <= smul(a_r[1][2], a_r[2][1]);
      pm_r[1][0] <= smul(a_r[1][2], a_r[2][0]); pn_r[1][0] <= smul(a_r[1][0], a_r[2][2]);
      pm_r[2][0] <= smul(a_r[1][0], a_r[2][1]); pn_r[2][0] <= smul(a_r[1][1], a_r[2][0]);
      pm_r[0][1] <= smul(a_r[0][2], a_r[2][1]); pn_r[0][1] <= smul(a_r[0][1], a_r[2][2]);
      pm_r[1][1] <= smul(a_r[0][0], a_r[2][2]); pn_r[1][1] <= smul(a_r[0][2], a_r[2][0]);
      pm_r[2][1] <= smul(a_r[0][1], a_r[2][0]); pn_r[2][1] <= smul(a_r[0][0], a_r[2][1]);
      pm_r[0][2] <= smul(a_r[0][1], a_r[1][2]); pn_r[0][2] <= smul(a_r[0][2], a_r[1][1]);
      pm_r[1][2] <= smul(a_r[0][2], a_r[1][0]); pn_r[1][2] <= smul(a_r[0][0], a_r[1][2]);
      pm_r[2][2] <= smul(a_r[0][0], a_r[1][1]); pn_r[2][2] <= smul(a_r[0][1], a_r[1][0]);

      for (int i = 0; i < 3; i++) begin
        r0_s2_r[i] <= a_r[0][i];
        r0_s3_r[i] <= r0_s2_r[i];
        b_s2_r[i]  <= b_r[i];
        b_s3_r[i]  <= b_s2_r[i];
        for (int j = 0; j < 3; j++) begin
          adj_r[i][j] <= (2*W+1)'(pm_r[i][j]) - (2*W+1)'(pn_r[i][j]);
        end
      end
    end
  end

  assign det_c[0] = adj_r[0][0];
  assign det_c[1] = adj_r[1][0];
  assign det_c[2] = adj_r[2][0];

  lss_dot3 #(.W(W), .PW(PW)) u_det (
    .clk (clk), .adv (adv), .x (r0_s3_r), .c (det_c), .sum (det_sum)
  );

  for (genvar i = 0; i < 3; i++) begin : g_lane
    logic signed [2*W:0] row_c [3];
    assign row_c[0] = adj_r[i][0];
    assign row_c[1] = adj_r[i][1];
    assign row_c[2] = adj_r[i][2];

    lss_dot3 #(.W(W), .PW(PW)) u_num (
      .clk (clk), .adv (adv), .x (b_s3_r), .c (row_c), .sum (n_sum[i])
    );

    lss_lane #(.W(W), .F(FRACTION_BITS)) u_lane (
      .clk    (clk),
      .adv    (adv),
      .num_in (n_sum[i]),
      .det_in (det_sum),
      .sol    (sol[i]),
      .flags  (flg[i])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sol_r[i] <= sol[i];
      end
      singular_r <= flg[0].zero;
      clipped_r  <= flg[0].clip | flg[1].clip | flg[2].clip;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_sol_0    = sol_r[0];
  assign out_sol_1    = sol_r[1];
  assign out_sol_2    = sol_r[2];
  assign out_singular = singular_r;
  assign out_clipped  = clipped_r;

`ifndef SYNTHESIS
  a_singular_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |->
      !out_clipped && out_sol_0 == '0 && out_sol_1 == '0 && out_sol_2 == '0)
    else $error("singular result with nonzero solution or clip");

  a_accept_enters : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> v_r[0])
    else $error("accepted request did not enter the pipeline");

  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
`endif

endmodule
